// ===== rtl/jsu_pkg.sv =====
// Shared types, codes and helper functions of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_unit.
package jsu_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [3:0] ERR_MISSING_QUOTE = 4'd0;
	localparam logic [3:0] ERR_CONTROL_BYTE  = 4'd1;
	localparam logic [3:0] ERR_UNTERMINATED  = 4'd2;
	localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd3;
	localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
	localparam logic [3:0] ERR_TRUNC_HEX     = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW       = 4'd7;
	localparam logic [3:0] ERR_LONE_HIGH     = 4'd8;
	localparam logic [3:0] ERR_LONE_LOW      = 4'd9;

	// One queued job: up to four result words sharing a kind.
	typedef struct packed {
		logic [1:0]      kind;
		logic [3:0]      code;
		logic [1:0]      final_idx;
		logic [3:0][7:0] bytes;
	} job_t;

	function automatic job_t mk_byte(input logic [7:0] b);
		job_t j;
		j           = '0;
		j.kind      = KIND_DATA;
		j.bytes[0]  = b;
		return j;
	endfunction

	function automatic job_t mk_end();
		job_t j;
		j      = '0;
		j.kind = KIND_END;
		return j;
	endfunction

	function automatic job_t mk_err(input logic [3:0] code);
		job_t j;
		j      = '0;
		j.kind = KIND_ERROR;
		j.code = code;
		return j;
	endfunction

	// Returns the digit value in the low four bits and a flag in bit 4 for a non-hex byte.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= "0" && c <= "9") begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic job_t mk_utf8(input logic [20:0] cp);
		job_t j;
		j      = '0;
		j.kind = KIND_DATA;
		if (cp <= 21'h7F) begin
			j.bytes[0]  = cp[7:0];
			j.final_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			j.bytes[0]  = {3'b110, cp[10:6]};
			j.bytes[1]  = {2'b10, cp[5:0]};
			j.final_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			j.bytes[0]  = {4'b1110, cp[15:12]};
			j.bytes[1]  = {2'b10, cp[11:6]};
			j.bytes[2]  = {2'b10, cp[5:0]};
			j.final_idx = 2'd2;
		end else begin
			j.bytes[0]  = {5'b11110, cp[20:18]};
			j.bytes[1]  = {2'b10, cp[17:12]};
			j.bytes[2]  = {2'b10, cp[11:6]};
			j.bytes[3]  = {2'b10, cp[5:0]};
			j.final_idx = 2'd3;
		end
		return j;
	endfunction

endpackage

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// JSON string unescaper with UTF-8 output; top level.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// The block takes one input word per cycle while its four-entry job queue has room, and
// gives one result word per cycle while the output is not stalled; a \u escape that yields
// several UTF-8 bytes gives one result word per byte, while input goes on filling the queue. The parser
// holds the string state, the queue lets the two sides stall apart, and the serialiser sets
// the output rate. A result passes through a queue entry and then the output register.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [3:0] error_code,
	output logic       last
);

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic not_empty;
	job_t new_job;
	job_t head_job;

	assign data_stall = full;
	assign accept     = data_valid && !full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.job          (new_job)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (new_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head_job  (head_job)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (not_empty),
		.job          (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.error_code   (error_code),
		.last         (last)
	);

endmodule

// ===== rtl/jsu_front.sv =====
// Front part: accepts input words, runs the string parser and issues jobs.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       push,
	output job_t       job
);

	typedef enum logic [2:0] {
		M_IDLE, M_BODY, M_ESC, M_HEX1, M_PAIR_BS, M_PAIR_U, M_HEX2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [15:0] hex_value_q, hex_value_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [9:0]  high_half_q, high_half_d;
	logic        has_job;
	logic [4:0]  digit;
	logic [15:0] hex_next;
	logic [10:0] plane;

	assign digit    = hex_digit(data_byte);
	assign hex_next = {hex_value_q[11:0], digit[3:0]};
	assign plane    = {1'b0, high_half_q} + 11'h040;

	always_comb begin
		mode_d      = mode_q;
		hex_value_d = hex_value_q;
		hex_count_d = hex_count_q;
		high_half_d = high_half_q;
		has_job     = 1'b0;
		job         = '0;
		unique case (mode_q)
			M_BODY: begin
				has_job = 1'b1;
				if (end_of_input) begin
					job    = mk_err(ERR_UNTERMINATED);
					mode_d = M_IDLE;
				end else if (data_byte == "\"") begin
					job    = mk_end();
					mode_d = M_IDLE;
				end else if (data_byte == "\\") begin
					has_job = 1'b0;
					mode_d  = M_ESC;
				end else if (data_byte < 8'h20) begin
					job    = mk_err(ERR_CONTROL_BYTE);
					mode_d = M_IDLE;
				end else begin
					job = mk_byte(data_byte);
				end
			end
			M_ESC: begin
				has_job = 1'b1;
				mode_d  = M_BODY;
				if (end_of_input) begin
					job    = mk_err(ERR_TRUNC_ESCAPE);
					mode_d = M_IDLE;
				end else begin
					case (data_byte)
						"\"", "\\", "/": job = mk_byte(data_byte);
						"b": job = mk_byte(8'h08);
						"f": job = mk_byte(8'h0C);
						"n": job = mk_byte(8'h0A);
						"r": job = mk_byte(8'h0D);
						"t": job = mk_byte(8'h09);
						"u": begin
							has_job     = 1'b0;
							mode_d      = M_HEX1;
							hex_value_d = '0;
							hex_count_d = '0;
						end
						default: begin
							job    = mk_err(ERR_BAD_ESCAPE);
							mode_d = M_IDLE;
						end
					endcase
				end
			end
			M_HEX1, M_HEX2: begin
				if (end_of_input) begin
					has_job = 1'b1;
					job     = mk_err(ERR_TRUNC_HEX);
					mode_d  = M_IDLE;
				end else if (digit[4]) begin
					has_job = 1'b1;
					job     = mk_err(ERR_BAD_HEX);
					mode_d  = M_IDLE;
				end else begin
					hex_value_d = hex_next;
					hex_count_d = hex_count_q + 2'd1;
					if (hex_count_q == 2'd3) begin
						if (mode_q == M_HEX1) begin
							if (hex_next[15:10] == 6'b110110) begin
								high_half_d = hex_next[9:0];
								mode_d      = M_PAIR_BS;
							end else if (hex_next[15:10] == 6'b110111) begin
								has_job = 1'b1;
								job     = mk_err(ERR_LONE_LOW);
								mode_d  = M_IDLE;
							end else begin
								has_job = 1'b1;
								job     = mk_utf8({5'd0, hex_next});
								mode_d  = M_BODY;
							end
						end else begin
							has_job = 1'b1;
							if (hex_next[15:10] == 6'b110111) begin
								job    = mk_utf8({plane, hex_next[9:0]});
								mode_d = M_BODY;
							end else begin
								job    = mk_err(ERR_BAD_LOW);
								mode_d = M_IDLE;
							end
						end
					end
				end
			end
			M_PAIR_BS: begin
				if (end_of_input || data_byte != "\\") begin
					has_job = 1'b1;
					job     = mk_err(ERR_LONE_HIGH);
					mode_d  = M_IDLE;
				end else begin
					mode_d = M_PAIR_U;
				end
			end
			M_PAIR_U: begin
				if (end_of_input || data_byte != "u") begin
					has_job = 1'b1;
					job     = mk_err(ERR_LONE_HIGH);
					mode_d  = M_IDLE;
				end else begin
					mode_d      = M_HEX2;
					hex_value_d = '0;
					hex_count_d = '0;
				end
			end
			default: begin
				if (end_of_input || data_byte != "\"") begin
					has_job = 1'b1;
					job     = mk_err(ERR_MISSING_QUOTE);
					mode_d  = M_IDLE;
				end else begin
					mode_d = M_BODY;
				end
			end
		endcase
	end

	assign push = accept && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			hex_value_q <= '0;
			hex_count_q <= '0;
			high_half_q <= '0;
		end else if (accept) begin
			mode_q      <= mode_d;
			hex_value_q <= hex_value_d;
			hex_count_q <= hex_count_d;
			high_half_q <= high_half_d;
		end
	end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short job queue between the parser and the result serialiser.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output job_t head_job
);

	job_t                 entries_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full      = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign not_empty = (count_q != '0);
	assign head_job  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/jsu_back.sv =====
// Back part: splits each queued job into result words behind an output register.
// Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_avail,
	input  job_t       job,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [3:0] error_code,
	output logic       last
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;

	assign load   = job_avail && (!result_valid || !result_stall);
	assign at_end = (idx_q == job.final_idx);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (load) begin
				result_valid <= 1'b1;
				idx_q        <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte   <= job.bytes[idx_q];
			kind       <= job.kind;
			error_code <= job.code;
			last       <= at_end;
		end
	end

endmodule

// ===== tb/sv/json_string_unescape_utf8_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for json_string_unescape_utf8_unit: directed and random JSON string text,
// checked word by word against a behavioural predictor held in this file.
// Depends on jsu_pkg for the result kinds and error codes.
module json_string_unescape_utf8_unit_tb;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	typedef enum logic [2:0] {
		ST_WAIT_QUOTE,
		ST_BODY,
		ST_ESCAPE,
		ST_HEX_FIRST,
		ST_PAIR_BSLASH,
		ST_PAIR_U,
		ST_HEX_SECOND
	} parse_state_e;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] error_code;
		logic       last;
	} result_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_stall;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_input = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [3:0] error_code;
	logic       last;

	logic       hold_on = 1'b0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         words_sent = 0;
	int         words_checked = 0;
	int         data_seen = 0;
	int         ends_seen = 0;
	int         errors_seen = 0;
	int         mismatches = 0;
	int         cycle_count = 0;

	result_word_t expected_results[$];

	parse_state_e parse_state = ST_WAIT_QUOTE;
	logic [15:0]  hex_acc = '0;
	logic [1:0]   hex_cnt = '0;
	logic [9:0]   high_half = '0;

	json_string_unescape_utf8_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.end_of_input(end_of_input),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.kind(kind),
		.error_code(error_code),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic void emit(input logic [7:0] b, input logic [1:0] k,
		input logic [3:0] code);
		result_word_t w;
		w.out_byte = b;
		w.kind = k;
		w.error_code = code;
		w.last = 1'b0;
		expected_results.insert(expected_results.size(), w);
	endfunction

	function automatic void fail_with(input logic [3:0] code);
		parse_state = ST_WAIT_QUOTE;
		emit(8'h00, KIND_ERROR, code);
	endfunction

	function automatic logic [4:0] hex_value_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b0, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			return {1'b0, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			return {1'b0, 4'(c - "A" + 8'd10)};
		end
		return 5'h10;
	endfunction

	function automatic void emit_code_point(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			emit(cp[7:0], KIND_DATA, 4'd0);
		end else if (cp <= 21'h7FF) begin
			emit({3'b110, cp[10:6]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
		end else if (cp <= 21'hFFFF) begin
			emit({4'b1110, cp[15:12]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[11:6]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
		end else begin
			emit({5'b11110, cp[20:18]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[17:12]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[11:6]}, KIND_DATA, 4'd0);
			emit({2'b10, cp[5:0]}, KIND_DATA, 4'd0);
		end
	endfunction

	function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
		int          n_prior;
		logic [4:0]  d;
		logic [15:0] v;
		result_word_t w;
		n_prior = expected_results.size();
		case (parse_state)
			ST_BODY: begin
				if (eoi) begin
					fail_with(ERR_UNTERMINATED);
				end else if (c == CH_QUOTE) begin
					parse_state = ST_WAIT_QUOTE;
					emit(8'h00, KIND_END, 4'd0);
				end else if (c == CH_BSLASH) begin
					parse_state = ST_ESCAPE;
				end else if (c < 8'h20) begin
					fail_with(ERR_CONTROL_BYTE);
				end else begin
					emit(c, KIND_DATA, 4'd0);
				end
			end
			ST_ESCAPE: begin
				if (eoi) begin
					fail_with(ERR_TRUNC_ESCAPE);
				end else begin
					parse_state = ST_BODY;
					case (c)
						CH_QUOTE, CH_BSLASH, "/": emit(c, KIND_DATA, 4'd0);
						"b": emit(8'h08, KIND_DATA, 4'd0);
						"f": emit(8'h0C, KIND_DATA, 4'd0);
						"n": emit(8'h0A, KIND_DATA, 4'd0);
						"r": emit(8'h0D, KIND_DATA, 4'd0);
						"t": emit(8'h09, KIND_DATA, 4'd0);
						CH_U: begin
							parse_state = ST_HEX_FIRST;
							hex_acc = '0;
							hex_cnt = '0;
						end
						default: fail_with(ERR_BAD_ESCAPE);
					endcase
				end
			end
			ST_HEX_FIRST, ST_HEX_SECOND: begin
				d = hex_value_of(c);
				if (eoi) begin
					fail_with(ERR_TRUNC_HEX);
				end else if (d[4]) begin
					fail_with(ERR_BAD_HEX);
				end else begin
					hex_acc = {hex_acc[11:0], d[3:0]};
					if (hex_cnt != 2'd3) begin
						hex_cnt = hex_cnt + 2'd1;
					end else begin
						hex_cnt = '0;
						v = hex_acc;
						if (parse_state == ST_HEX_FIRST) begin
							if (v >= 16'hD800 && v <= 16'hDBFF) begin
								high_half = 10'(v - 16'hD800);
								parse_state = ST_PAIR_BSLASH;
							end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
								fail_with(ERR_LONE_LOW);
							end else begin
								parse_state = ST_BODY;
								emit_code_point({5'd0, v});
							end
						end else if (v < 16'hDC00 || v > 16'hDFFF) begin
							fail_with(ERR_BAD_LOW);
						end else begin
							parse_state = ST_BODY;
							emit_code_point(21'h10000 + {1'b0, high_half, 10'd0}
								+ 21'(v - 16'hDC00));
						end
					end
				end
			end
			ST_PAIR_BSLASH: begin
				if (eoi || c != CH_BSLASH) begin
					fail_with(ERR_LONE_HIGH);
				end else begin
					parse_state = ST_PAIR_U;
				end
			end
			ST_PAIR_U: begin
				if (eoi || c != CH_U) begin
					fail_with(ERR_LONE_HIGH);
				end else begin
					parse_state = ST_HEX_SECOND;
					hex_acc = '0;
					hex_cnt = '0;
				end
			end
			default: begin
				if (eoi || c != CH_QUOTE) begin
					fail_with(ERR_MISSING_QUOTE);
				end else begin
					parse_state = ST_BODY;
				end
			end
		endcase
		if (expected_results.size() > n_prior) begin
			w = expected_results[expected_results.size() - 1];
			w.last = 1'b1;
			expected_results[expected_results.size() - 1] = w;
		end
	endfunction

	task automatic check_result();
		result_word_t want;
		words_checked++;
		case (kind)
			KIND_DATA: data_seen++;
			KIND_END: ends_seen++;
			default: errors_seen++;
		endcase
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t: unexpected word byte=%h kind=%0d code=%0d last=%b",
					$realtime, out_byte, kind, error_code, last);
			end
		end else begin
			want = expected_results.pop_front();
			if (out_byte !== want.out_byte || kind !== want.kind
				|| error_code !== want.error_code || last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: expected byte=%h kind=%0d code=%0d last=%b,",
						$realtime, want.out_byte, want.kind, want.error_code, want.last,
						" got byte=%h kind=%0d code=%0d last=%b",
						out_byte, kind, error_code, last);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			check_result();
		end
		result_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_word(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_input <= e;
		@(posedge clk);
		while (data_stall) begin
			@(posedge clk);
		end
		unescape_byte(b, e);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], 1'b0);
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return "0" + 8'(n);
		end
		return ($urandom_range(1) ? "A" : "a") + 8'(n - 4'd10);
	endfunction

	function automatic logic [7:0] escape_letter(input int i);
		case (i)
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	task automatic add_unicode(ref logic [8:0] txt[$], input logic [15:0] v);
		txt.insert(txt.size(), {1'b0, CH_BSLASH});
		txt.insert(txt.size(), {1'b0, CH_U});
		txt.insert(txt.size(), {1'b0, hex_char(v[15:12])});
		txt.insert(txt.size(), {1'b0, hex_char(v[11:8])});
		txt.insert(txt.size(), {1'b0, hex_char(v[7:4])});
		txt.insert(txt.size(), {1'b0, hex_char(v[3:0])});
	endtask

	task automatic send_random_string(input bit noisy);
		logic [8:0]  txt[$];
		logic [7:0]  b;
		logic [15:0] v;
		int          cut;
		if (noisy && $urandom_range(99) < 10) begin
			send_word(8'($urandom), 1'($urandom));
		end
		txt.insert(txt.size(), {1'b0, CH_QUOTE});
		repeat ($urandom_range(6)) begin
			case ($urandom_range(4))
				0: begin
					do begin
						b = 8'($urandom_range(8'h20, 8'hFF));
					end while (b == CH_QUOTE || b == CH_BSLASH);
					txt.insert(txt.size(), {1'b0, b});
				end
				1: begin
					txt.insert(txt.size(), {1'b0, CH_BSLASH});
					txt.insert(txt.size(), {1'b0, escape_letter($urandom_range(7))});
				end
				2: begin
					case ($urandom_range(2))
						0: v = 16'($urandom_range(16'h7F));
						1: v = 16'($urandom_range(16'h80, 16'h7FF));
						default: v = 16'($urandom_range(16'h800, 16'hFFFF));
					endcase
					if (v >= 16'hD800 && v <= 16'hDFFF) begin
						v = v ^ 16'h4000;
					end
					add_unicode(txt, v);
				end
				3: begin
					add_unicode(txt, 16'hD800 | 16'($urandom_range(1023)));
					add_unicode(txt, 16'hDC00 | 16'($urandom_range(1023)));
				end
				default: begin
					if (!noisy) begin
						txt.insert(txt.size(), {1'b0, 8'($urandom_range(8'h61, 8'h7A))});
					end else begin
						case ($urandom_range(2))
							0: begin
								add_unicode(txt, 16'hD800 | 16'($urandom_range(1023)));
								add_unicode(txt, 16'($urandom));
							end
							1: add_unicode(txt, 16'hDC00 | 16'($urandom_range(1023)));
							default: add_unicode(txt, 16'hD800 | 16'($urandom_range(1023)));
						endcase
					end
				end
			endcase
		end
		txt.insert(txt.size(), {1'b0, CH_QUOTE});
		if (noisy && $urandom_range(99) < 30) begin
			cut = $urandom_range(txt.size() - 1);
			case ($urandom_range(2))
				0: txt[cut] = {1'b1, 8'($urandom)};
				1: txt[cut] = {1'b0, 8'($urandom)};
				default: txt[cut] = {1'b0, 8'($urandom_range(8'h1F))};
			endcase
			txt = txt[0:cut];
		end
		foreach (txt[i]) begin
			send_word(txt[i][7:0], txt[i][8]);
		end
	endtask

	task automatic test_errors();
		send_word(8'h5A, 1'b1);
		send_word(8'h00, 1'b0);
		send_text("\"");
		send_word(8'h1F, 1'b0);
		send_text("\"");
		send_word(8'hFF, 1'b1);
		send_text("\"\\");
		send_word(8'h00, 1'b1);
		send_text("\"\\x");
		send_text("\"\\u1");
		send_word(8'h22, 1'b1);
		send_text("\"\\ug");
		send_text("\"\\uD800\\u0041");
		send_text("\"\\uDBFFx");
		send_text("\"\\udc00");
	endtask

	task automatic test_code_points();
		send_text("\"\\u0000\\u007F\\u0080\\u07FF\\u0800\\uFFFF\\uD800\\uDC00\\uDBFF\\uDFFF");
		send_word(8'hFF, 1'b0);
		send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t \"");
	endtask

	task automatic test_random_phase(input int n_words, input int sender_pct,
		input int receiver_pct);
		int start;
		send_idle_pct = sender_pct;
		recv_stall_pct <= receiver_pct;
		start = words_sent;
		while (words_sent - start < n_words) begin
			send_random_string(1'b1);
		end
	endtask

	task automatic test_backpressure();
		int start;
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		start = words_sent;
		fork
			begin
				hold_on <= 1'b1;
				repeat (80) @(posedge clk);
				hold_on <= 1'b0;
			end
			while (words_sent - start < 40) begin
				send_random_string(1'b0);
			end
		join
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_errors();
		test_code_points();
		test_random_phase(60, 0, 0);
		test_random_phase(60, 76, 0);
		test_random_phase(60, 0, 76);
		test_random_phase(60, 35, 35);
		test_backpressure();
		data_valid <= 1'b0;
		recv_stall_pct <= 20;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d words: directed errors, code point extremes, four idle mixes.",
			words_sent);
		$display("Checked %0d results: %0d data bytes, %0d string ends, %0d errors; %0d mismatches.",
			words_checked, data_seen, ends_seen, errors_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_unit.sv
tb/sv/json_string_unescape_utf8_unit_tb.sv
